### rtl/absc_pkg.sv
// Shared widths, payload type and helpers for the 2D box/circle collision core.
// Used by absc_front, absc_fifo, absc_back and the top level.
package absc_pkg;

  localparam int CW  = 32;            // coordinate width
  localparam int FB  = 16;            // fraction bits
  localparam int NW  = 18;            // normal component width
  localparam int MW  = CW + 1;        // magnitude of a coordinate difference
  localparam int HW  = (MW + 1) / 2;  // low half for split squaring
  localparam int SW  = 2 * MW + 1;    // sum of two squares
  localparam int RW  = (SW + 1) / 2;  // root width
  localparam int RMW = 2 * RW;        // sqrt working width
  localparam int DW  = RW + 1;        // signed distance before saturation
  localparam int QW  = FB + 1;        // unit quotient width

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [NW-1:0] ONE_FX     = NW'(1) << FB;
  localparam logic [NW-1:0] NEG_ONE_FX = ~ONE_FX + NW'(1);

  localparam logic [DW-1:0] DMAX = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = ~DMAX;

  typedef struct packed {
    logic            circ;
    logic            hit;
    logic [CW-1:0]   distance;
    logic [NW-1:0]   nx;
    logic [NW-1:0]   ny;
    logic            sx;
    logic            sy;
    logic [MW-1:0]   mx;
    logic [MW-1:0]   my;
    logic [CW-2:0]   rad;
  } front_t;

  function automatic logic [CW-1:0] sat_dist(input logic signed [DW-1:0] v);
    logic [CW-1:0] r;
    if (v > $signed(DMAX)) r = DMAX[CW-1:0];
    else if (v < $signed(DMIN)) r = DMIN[CW-1:0];
    else r = v[CW-1:0];
    return r;
  endfunction

endpackage

### rtl/absc_front.sv
// Front stage: accepts a query, evaluates box mode fully and clamps the circle.
// Depends on absc_pkg.
module absc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      action_i,
  input  logic signed [absc_pkg::CW-1:0] a_min_x_i,
  input  logic signed [absc_pkg::CW-1:0] a_min_y_i,
  input  logic signed [absc_pkg::CW-1:0] a_max_x_i,
  input  logic signed [absc_pkg::CW-1:0] a_max_y_i,
  input  logic signed [absc_pkg::CW-1:0] b_min_x_i,
  input  logic signed [absc_pkg::CW-1:0] b_min_y_i,
  input  logic signed [absc_pkg::CW-1:0] b_max_x_i,
  input  logic signed [absc_pkg::CW-1:0] b_max_y_i,
  input  logic signed [absc_pkg::CW-1:0] center_x_i,
  input  logic signed [absc_pkg::CW-1:0] center_y_i,
  input  logic [absc_pkg::CW-2:0]        radius_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output absc_pkg::front_t          q_data_o
);

  localparam int CW = absc_pkg::CW;
  localparam int MW = absc_pkg::MW;

  logic             vld_q, vld_d;
  absc_pkg::front_t dat_q, dat_d;
  logic             accept;

  logic signed [MW-1:0] gx1, gx2, gy1, gy2, gx, gy, md;
  logic signed [MW-1:0] dx, dy;
  logic signed [CW-1:0] clx, cly;
  logic                 hit_b;
  logic [absc_pkg::NW-1:0] nx_b, ny_b;

  assign full     = vld_q && q_full_i;
  assign accept   = push && !full;
  assign q_push_o = vld_q && !q_full_i;
  assign q_data_o = dat_q;

  always_comb begin
    gx1 = MW'(b_min_x_i) - MW'(a_max_x_i);
    gx2 = MW'(a_min_x_i) - MW'(b_max_x_i);
    gy1 = MW'(b_min_y_i) - MW'(a_max_y_i);
    gy2 = MW'(a_min_y_i) - MW'(b_max_y_i);
    gx  = (gx1 > gx2) ? gx1 : gx2;
    gy  = (gy1 > gy2) ? gy1 : gy2;
    md  = (gx > gy) ? gx : gy;
    hit_b = md[MW-1];
    nx_b  = '0;
    ny_b  = '0;
    // -gx >= -gy is gy >= gx
    if (hit_b) begin
      if (a_min_x_i <= b_min_x_i && b_min_x_i <= a_max_x_i) begin
        if (b_max_x_i > a_max_x_i) begin
          if (gy >= gx) ny_b = (a_min_y_i >= b_min_y_i) ? absc_pkg::NEG_ONE_FX
                                                       : absc_pkg::ONE_FX;
          else nx_b = absc_pkg::ONE_FX;
        end else begin
          ny_b = (b_max_y_i > a_max_y_i) ? absc_pkg::ONE_FX : absc_pkg::NEG_ONE_FX;
        end
      end else if (b_max_x_i >= a_max_x_i) begin
        ny_b = (b_max_y_i >= a_max_y_i) ? absc_pkg::ONE_FX : absc_pkg::NEG_ONE_FX;
      end else if (b_max_y_i >= a_max_y_i) begin
        ny_b = absc_pkg::ONE_FX;
      end else if (gy >= gx) begin
        ny_b = absc_pkg::NEG_ONE_FX;
      end else begin
        nx_b = absc_pkg::NEG_ONE_FX;
      end
    end

    // clamp: at or below min first, then at or above max
    if (center_x_i <= a_min_x_i) clx = a_min_x_i;
    else if (center_x_i >= a_max_x_i) clx = a_max_x_i;
    else clx = center_x_i;
    if (center_y_i <= a_min_y_i) cly = a_min_y_i;
    else if (center_y_i >= a_max_y_i) cly = a_max_y_i;
    else cly = center_y_i;
    dx = MW'(clx) - MW'(center_x_i);
    dy = MW'(cly) - MW'(center_y_i);

    dat_d.circ     = action_i;
    dat_d.hit      = hit_b;
    dat_d.distance = absc_pkg::sat_dist(absc_pkg::DW'(md));
    dat_d.nx       = nx_b;
    dat_d.ny       = ny_b;
    dat_d.sx       = dx[MW-1];
    dat_d.sy       = dy[MW-1];
    dat_d.mx       = dx[MW-1] ? MW'(-dx) : MW'(dx);
    dat_d.my       = dy[MW-1] ? MW'(-dy) : MW'(dy);
    dat_d.rad      = radius_i;
  end

  always_comb begin
    if (accept) vld_d = 1'b1;
    else if (q_push_o) vld_d = 1'b0;
    else vld_d = vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else vld_q <= vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) dat_q <= dat_d;
  end

endmodule

### rtl/absc_fifo.sv
// Short queue between front and back; combinational read of the head entry.
// Depends on absc_pkg.
module absc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  absc_pkg::front_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output absc_pkg::front_t rdata_o,
  output logic             empty_o
);

  localparam int AW = absc_pkg::FIFO_AW;

  absc_pkg::front_t mem_q [absc_pkg::FIFO_DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = cnt_q == (AW+1)'(absc_pkg::FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(absc_pkg::FIFO_DEPTH - 1)) ? '0 : wp_q + AW'(1);
      if (pop_i)  rp_q <= (rp_q == AW'(absc_pkg::FIFO_DEPTH - 1)) ? '0 : rp_q + AW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

endmodule

### rtl/absc_back.sv
// Back pipeline: split squaring, bit-per-stage square root, bit-per-stage unit
// normal division, and the result register. Depends on absc_pkg.
module absc_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  absc_pkg::front_t        q_data_i,
  output logic                    q_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output logic                    hit_o,
  output logic [absc_pkg::CW-1:0] distance_o,
  output logic [absc_pkg::NW-1:0] normal_x_o,
  output logic [absc_pkg::NW-1:0] normal_y_o
);

  localparam int NW  = absc_pkg::NW;
  localparam int MW  = absc_pkg::MW;
  localparam int HW  = absc_pkg::HW;
  localparam int LW  = MW - HW;
  localparam int SW  = absc_pkg::SW;
  localparam int RW  = absc_pkg::RW;
  localparam int RMW = absc_pkg::RMW;
  localparam int DW  = absc_pkg::DW;
  localparam int QW  = absc_pkg::QW;
  localparam int FB  = absc_pkg::FB;

  logic en;
  logic out_vld_q;

  assign en      = !out_vld_q || pop;
  assign q_pop_o = en && !q_empty_i;
  assign empty   = !out_vld_q;

  // stage A: partial products
  logic             a_v_q;
  absc_pkg::front_t a_p_q;
  logic [2*LW-1:0]  a_xhh_q, a_yhh_q;
  logic [MW-1:0]    a_xhl_q, a_yhl_q;
  logic [2*HW-1:0]  a_xll_q, a_yll_q;

  // stage B: squares
  logic             b_v_q;
  absc_pkg::front_t b_p_q;
  logic [SW-1:0]    b_sqx_q, b_sqy_q;

  // sqrt stages
  logic             sq_v_q   [RW+1];
  absc_pkg::front_t sq_p_q   [RW+1];
  logic [RMW-1:0]   sq_rem_q [RW+1];
  logic [RMW-1:0]   sq_res_q [RW+1];

  // divide stages
  logic             dv_v_q   [FB+1];
  absc_pkg::front_t dv_p_q   [FB+1];
  logic [RW-1:0]    dv_len_q [FB+1];
  logic [RW:0]      dv_rx_q  [FB+1];
  logic [RW:0]      dv_ry_q  [FB+1];
  logic [QW-1:0]    dv_qx_q  [FB+1];
  logic [QW-1:0]    dv_qy_q  [FB+1];
  logic             dv_z_q   [FB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      sq_v_q[0] <= 1'b0;
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      a_v_q     <= !q_empty_i;
      b_v_q     <= a_v_q;
      sq_v_q[0] <= b_v_q;
      dv_v_q[0] <= sq_v_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_p_q   <= q_data_i;
      a_xhh_q <= q_data_i.mx[MW-1:HW] * q_data_i.mx[MW-1:HW];
      a_xhl_q <= q_data_i.mx[MW-1:HW] * q_data_i.mx[HW-1:0];
      a_xll_q <= q_data_i.mx[HW-1:0] * q_data_i.mx[HW-1:0];
      a_yhh_q <= q_data_i.my[MW-1:HW] * q_data_i.my[MW-1:HW];
      a_yhl_q <= q_data_i.my[MW-1:HW] * q_data_i.my[HW-1:0];
      a_yll_q <= q_data_i.my[HW-1:0] * q_data_i.my[HW-1:0];

      b_p_q   <= a_p_q;
      b_sqx_q <= (SW'(a_xhh_q) << (2*HW)) + (SW'(a_xhl_q) << (HW+1)) + SW'(a_xll_q);
      b_sqy_q <= (SW'(a_yhh_q) << (2*HW)) + (SW'(a_yhl_q) << (HW+1)) + SW'(a_yll_q);

      sq_p_q[0]   <= b_p_q;
      sq_rem_q[0] <= RMW'(b_sqx_q) + RMW'(b_sqy_q);
      sq_res_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam logic [RMW-1:0] BIT = RMW'(1) << (2*(RW-1-k));
    logic [RMW-1:0] trial;
    logic           ge;
    assign trial = sq_res_q[k] | BIT;
    assign ge    = sq_rem_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k+1] <= 1'b0;
      else if (en) sq_v_q[k+1] <= sq_v_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_p_q[k+1]   <= sq_p_q[k];
        sq_rem_q[k+1] <= ge ? sq_rem_q[k] - trial : sq_rem_q[k];
        sq_res_q[k+1] <= ge ? ((sq_res_q[k] >> 1) | BIT) : (sq_res_q[k] >> 1);
      end
    end
  end

  // stage D: circle distance, hit, first quotient bit
  logic [RW-1:0]          len;
  logic signed [DW-1:0]   cdist;
  logic [RW:0]            rx0, ry0;
  logic                   gex0, gey0;
  absc_pkg::front_t       d_p;

  always_comb begin
    len   = sq_res_q[RW][RW-1:0];
    cdist = DW'(len) - DW'(sq_p_q[RW].rad);
    rx0   = (RW+1)'(sq_p_q[RW].mx);
    ry0   = (RW+1)'(sq_p_q[RW].my);
    gex0  = rx0 >= (RW+1)'(len);
    gey0  = ry0 >= (RW+1)'(len);
    d_p   = sq_p_q[RW];
    if (sq_p_q[RW].circ) begin
      d_p.hit      = len < RW'(sq_p_q[RW].rad);
      d_p.distance = absc_pkg::sat_dist(cdist);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_p_q[0]   <= d_p;
      dv_len_q[0] <= len;
      dv_rx_q[0]  <= gex0 ? rx0 - (RW+1)'(len) : rx0;
      dv_ry_q[0]  <= gey0 ? ry0 - (RW+1)'(len) : ry0;
      dv_qx_q[0]  <= QW'(gex0);
      dv_qy_q[0]  <= QW'(gey0);
      dv_z_q[0]   <= len == '0;
    end
  end

  for (genvar j = 0; j < FB; j++) begin : g_div
    logic [RW:0] rx2, ry2;
    logic        gex, gey;
    assign rx2 = {dv_rx_q[j][RW-1:0], 1'b0};
    assign ry2 = {dv_ry_q[j][RW-1:0], 1'b0};
    assign gex = rx2 >= (RW+1)'(dv_len_q[j]);
    assign gey = ry2 >= (RW+1)'(dv_len_q[j]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[j+1] <= 1'b0;
      else if (en) dv_v_q[j+1] <= dv_v_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_p_q[j+1]   <= dv_p_q[j];
        dv_len_q[j+1] <= dv_len_q[j];
        dv_rx_q[j+1]  <= gex ? rx2 - (RW+1)'(dv_len_q[j]) : rx2;
        dv_ry_q[j+1]  <= gey ? ry2 - (RW+1)'(dv_len_q[j]) : ry2;
        dv_qx_q[j+1]  <= {dv_qx_q[j][QW-2:0], gex};
        dv_qy_q[j+1]  <= {dv_qy_q[j][QW-2:0], gey};
        dv_z_q[j+1]   <= dv_z_q[j];
      end
    end
  end

  // result register
  logic [NW-1:0] nx_d, ny_d, qx, qy;

  always_comb begin
    qx   = NW'(dv_qx_q[FB]);
    qy   = NW'(dv_qy_q[FB]);
    nx_d = dv_p_q[FB].nx;
    ny_d = dv_p_q[FB].ny;
    if (dv_p_q[FB].circ) begin
      if (dv_z_q[FB]) begin
        nx_d = '0;
        ny_d = '0;
      end else begin
        nx_d = dv_p_q[FB].sx ? NW'(~qx + NW'(1)) : qx;
        ny_d = dv_p_q[FB].sy ? NW'(~qy + NW'(1)) : qy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= dv_v_q[FB];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o      <= dv_p_q[FB].hit;
      distance_o <= dv_p_q[FB].distance;
      normal_x_o <= nx_d;
      normal_y_o <= ny_d;
    end
  end

endmodule

### rtl/aabb_box_sphere_collision_2d_core.sv
// Top level of the 2D box/box and box/circle collision core.
// Instantiates absc_front, absc_fifo and absc_back; depends on absc_pkg.
//
//  channel | handshake    | beat
//  --------+--------------+-------------------------------------------------
//  query   | push / full  | action, box A, box B, circle center and radius
//  result  | pop / empty  | hit, distance, normal_x, normal_y
//
// One beat per cycle sustained. From the accepting edge (front register) a beat
// passes the queue write, 3 squaring stages, one sqrt stage per root bit (34 at
// the default widths), one divide stage per quotient bit (17) and the result
// register. Reset clears valid flags, queue pointers and count only. A stalled
// result freezes the back pipeline; queue and front take beats until they fill.
module aabb_box_sphere_collision_2d_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           action_i,
  input  logic signed [absc_pkg::CW-1:0] a_min_x_i,
  input  logic signed [absc_pkg::CW-1:0] a_min_y_i,
  input  logic signed [absc_pkg::CW-1:0] a_max_x_i,
  input  logic signed [absc_pkg::CW-1:0] a_max_y_i,
  input  logic signed [absc_pkg::CW-1:0] b_min_x_i,
  input  logic signed [absc_pkg::CW-1:0] b_min_y_i,
  input  logic signed [absc_pkg::CW-1:0] b_max_x_i,
  input  logic signed [absc_pkg::CW-1:0] b_max_y_i,
  input  logic signed [absc_pkg::CW-1:0] center_x_i,
  input  logic signed [absc_pkg::CW-1:0] center_y_i,
  input  logic [absc_pkg::CW-2:0]        radius_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           hit_o,
  output logic signed [absc_pkg::CW-1:0] distance_o,
  output logic signed [absc_pkg::NW-1:0] normal_x_o,
  output logic signed [absc_pkg::NW-1:0] normal_y_o
);

  logic             q_full, q_push, q_pop, q_empty;
  absc_pkg::front_t q_wdata, q_rdata;
  logic [absc_pkg::CW-1:0] sep;
  logic [absc_pkg::NW-1:0] nx, ny;

  absc_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .action_i, .a_min_x_i, .a_min_y_i, .a_max_x_i, .a_max_y_i,
    .b_min_x_i, .b_min_y_i, .b_max_x_i, .b_max_y_i,
    .center_x_i, .center_y_i, .radius_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  absc_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  absc_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .empty, .pop, .hit_o,
    .distance_o (sep),
    .normal_x_o (nx),
    .normal_y_o (ny)
  );

  assign distance_o = sep;
  assign normal_x_o = nx;
  assign normal_y_o = ny;

endmodule

### tb/collision_checker.sv
// Checker for the 2D box/circle collision core: watches the query and result
// channels, predicts each result and compares it. Depends on absc_pkg.
module collision_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           full,
  input  logic                           action_i,
  input  logic signed [absc_pkg::CW-1:0] a_min_x_i,
  input  logic signed [absc_pkg::CW-1:0] a_min_y_i,
  input  logic signed [absc_pkg::CW-1:0] a_max_x_i,
  input  logic signed [absc_pkg::CW-1:0] a_max_y_i,
  input  logic signed [absc_pkg::CW-1:0] b_min_x_i,
  input  logic signed [absc_pkg::CW-1:0] b_min_y_i,
  input  logic signed [absc_pkg::CW-1:0] b_max_x_i,
  input  logic signed [absc_pkg::CW-1:0] b_max_y_i,
  input  logic signed [absc_pkg::CW-1:0] center_x_i,
  input  logic signed [absc_pkg::CW-1:0] center_y_i,
  input  logic [absc_pkg::CW-2:0]        radius_i,
  input  logic                           empty,
  input  logic                           pop,
  input  logic                           hit_o,
  input  logic signed [absc_pkg::CW-1:0] distance_o,
  input  logic signed [absc_pkg::NW-1:0] normal_x_o,
  input  logic signed [absc_pkg::NW-1:0] normal_y_o,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                    hit;
    logic [absc_pkg::CW-1:0] distance;
    logic [absc_pkg::NW-1:0] nx;
    logic [absc_pkg::NW-1:0] ny;
  } contact_t;

  localparam longint ONE = longint'(1) << absc_pkg::FB;
  localparam longint CMAX = (longint'(1) << (absc_pkg::CW - 1)) - 1;

  contact_t contacts_q[$];
  int fails;

  function automatic longint max2(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint clamp_into(longint c, longint lo, longint hi);
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  // floor sqrt of a sum below 2^65
  function automatic longint unsigned floor_root(logic [103:0] s);
    logic [51:0] r;
    logic [51:0] t;
    r = '0;
    for (int b = 51; b >= 0; b--) begin
      t = r | (52'(1) << b);
      if (104'(t) * 104'(t) <= s) r = t;
    end
    return longint'(r);
  endfunction

  function automatic longint unit_of(longint comp, longint len);
    longint q;
    q = ((comp < 0 ? -comp : comp) * ONE) / len;
    return comp < 0 ? -q : q;
  endfunction

  function automatic contact_t predict_contact();
    contact_t c;
    longint amnx, amny, amxx, amxy, bmnx, bmny, bmxx, bmxy;
    longint gx, gy, md, ax, ay, sep, nx, ny, dx, dy, rad, len;
    logic hit;
    amnx = a_min_x_i; amny = a_min_y_i; amxx = a_max_x_i; amxy = a_max_y_i;
    hit = 0; sep = 0; nx = 0; ny = 0;
    if (!action_i) begin
      bmnx = b_min_x_i; bmny = b_min_y_i; bmxx = b_max_x_i; bmxy = b_max_y_i;
      gx = max2(bmnx - amxx, amnx - bmxx);
      gy = max2(bmny - amxy, amny - bmxy);
      md = max2(gx, gy);
      sep = md;
      if (md < 0) begin
        ax = -gx; ay = -gy; hit = 1;
        if (amnx <= bmnx && bmnx <= amxx) begin
          if (bmxx > amxx) begin
            if (ax >= ay) ny = (amny >= bmny) ? -ONE : ONE;
            else nx = ONE;
          end else ny = (bmxy > amxy) ? ONE : -ONE;
        end else if (bmxx >= amxx) ny = (bmxy >= amxy) ? ONE : -ONE;
        else if (bmxy >= amxy) ny = ONE;
        else if (ax >= ay) ny = -ONE;
        else nx = -ONE;
      end
    end else begin
      rad = longint'(radius_i);
      dx = clamp_into(longint'(center_x_i), amnx, amxx) - longint'(center_x_i);
      dy = clamp_into(longint'(center_y_i), amny, amxy) - longint'(center_y_i);
      // squares approach 2^64, so they are formed at full width
      len = floor_root(104'(dx) * 104'(dx) + 104'(dy) * 104'(dy));
      hit = len < rad;
      sep = len - rad;
      if (len != 0) begin
        nx = unit_of(dx, len);
        ny = unit_of(dy, len);
      end
    end
    if (sep > CMAX) sep = CMAX;
    if (sep < -CMAX - 1) sep = -CMAX - 1;
    c.hit = hit;
    c.distance = sep[absc_pkg::CW-1:0];
    c.nx = nx[absc_pkg::NW-1:0];
    c.ny = ny[absc_pkg::NW-1:0];
    return c;
  endfunction

  always @(posedge clk_i) begin
    contact_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (contacts_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result beat with nothing expected at %0t", $realtime);
        end else begin
          want = contacts_q.pop_front();
          if (want.hit !== hit_o || want.distance !== distance_o ||
              want.nx !== normal_x_o || want.ny !== normal_y_o) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp hit %0b dist %h nx %h ny %h, got %0b %h %h %h",
                       want.hit, want.distance, want.nx, want.ny,
                       hit_o, distance_o, normal_x_o, normal_y_o);
          end
        end
      end
      if (push && !full) contacts_q.push_back(predict_contact());
    end
  end

  assign fail_count_o = fails;
  assign pending_o = contacts_q.size();
endmodule

### tb/testbench.sv
// Top of the collision core testbench: clock, reset, query stimulus, result
// drain and verdict. Depends on absc_pkg, collision_checker and the core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = absc_pkg::CW;
  localparam int NW = absc_pkg::NW;
  localparam int RANDOM_QUERIES = 930;
  localparam longint SMAX = 32'sh7fffffff;
  localparam longint SMIN = -32'sh80000000;

  logic clk_i = 0, rst_ni = 0, push = 0, pop = 0, action_i = 0;
  logic full, empty, hit_o;
  logic signed [CW-1:0] a_min_x_i = 0, a_min_y_i = 0, a_max_x_i = 0, a_max_y_i = 0;
  logic signed [CW-1:0] b_min_x_i = 0, b_min_y_i = 0, b_max_x_i = 0, b_max_y_i = 0;
  logic signed [CW-1:0] center_x_i = 0, center_y_i = 0, distance_o;
  logic [CW-2:0] radius_i = 0;
  logic signed [NW-1:0] normal_x_o, normal_y_o;
  int fail_count, pending;
  bit quiet_phase, hold_done;

  aabb_box_sphere_collision_2d_core dut (.*);
  collision_checker checker_i (.*, .fail_count_o(fail_count), .pending_o(pending));

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 8000))) - 4000;
      2: return ($urandom_range(0, 1)) ? 32'sh7fffffff - $urandom_range(0, 3)
                                       : 32'sh80000000 + $urandom_range(0, 3);
      default: return $signed(32'($urandom_range(0, 2000000))) - 1000000;
    endcase
  endfunction

  // Send one beat; waits until accepted.
  task automatic send_query(logic act, longint c[10], longint r);
    push <= 1;
    action_i <= act;
    a_min_x_i <= CW'(c[0]); a_min_y_i <= CW'(c[1]);
    a_max_x_i <= CW'(c[2]); a_max_y_i <= CW'(c[3]);
    b_min_x_i <= CW'(c[4]); b_min_y_i <= CW'(c[5]);
    b_max_x_i <= CW'(c[6]); b_max_y_i <= CW'(c[7]);
    center_x_i <= CW'(c[8]); center_y_i <= CW'(c[9]); radius_i <= (CW-1)'(r);
    do @(posedge clk_i); while (full);
    if (!quiet_phase && $urandom_range(0, 99) < 6) begin
      push <= 0;
      @(posedge clk_i);
    end
  endtask

  task automatic random_query();
    longint c[10];
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 10; i++)
      c[i] = longint'(rand_coord($urandom_range(0, 9) < 7 ? mode : 0));
    // mostly well-formed boxes
    if ($urandom_range(0, 9) < 8) begin
      if (c[0] > c[2]) begin c[0] = c[0] ^ c[2]; c[2] = c[0] ^ c[2]; c[0] = c[0] ^ c[2]; end
      if (c[1] > c[3]) begin c[1] = c[1] ^ c[3]; c[3] = c[1] ^ c[3]; c[1] = c[1] ^ c[3]; end
      if (c[4] > c[6]) begin c[4] = c[4] ^ c[6]; c[6] = c[4] ^ c[6]; c[4] = c[4] ^ c[6]; end
      if (c[5] > c[7]) begin c[5] = c[5] ^ c[7]; c[7] = c[5] ^ c[7]; c[5] = c[5] ^ c[7]; end
    end
    send_query(1'($urandom_range(0, 1)), c,
               mode == 0 ? longint'($urandom() >> 1) : longint'($urandom_range(0, 3000)));
  endtask

  initial begin
    longint c[10];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: field extremes, overlap/miss in both modes, inverted box, center inside
    c = '{SMIN, SMIN, SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMAX};
    send_query(0, c, 0);
    send_query(1, c, 31'h7fffffff);
    c = '{SMAX, SMAX, SMIN, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMIN};
    send_query(0, c, 31'h7fffffff);
    send_query(1, c, 0);
    c = '{0, 0, 100, 100, 50, 50, 150, 80, 50, 50};
    send_query(0, c, 10);
    send_query(1, c, 10);
    c = '{0, 0, 100, 100, -50, 20, 60, 200, 200, 300};
    send_query(0, c, 400);
    send_query(1, c, 10);
    c = '{0, 0, 100, 100, -50, -50, 60, 40, -30, 50};
    send_query(0, c, 30);
    send_query(1, c, 31);
    c = '{0, 0, 100, 100, 20, 20, 80, 80, 100, 100};
    send_query(0, c, 0);
    send_query(1, c, 1);
    c = '{0, 0, 100, 100, -10, 30, 50, 60, -3, -4};
    send_query(0, c, 5);
    send_query(1, c, 6);
    c = '{0, 0, 100, 100, 101, 0, 200, 100, 150, 150};
    send_query(0, c, 0);
    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      quiet_phase = (i >= 300 && i < 500);
      random_query();
    end
    push <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("aabb_box_sphere_collision_2d_core test passed");
    else $display("aabb_box_sphere_collision_2d_core test failed");
    $finish;
  end

  // Result side: random stalls, one long hold-off to fill the core.
  initial begin
    int beats;
    beats = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) beats++;
      if (!hold_done && beats == 100) begin
        hold_done = 1;
        pop <= 0;
        repeat (200) @(posedge clk_i);
        pop <= 1;
      end else pop <= quiet_phase || $urandom_range(0, 99) >= 6;
    end
  end

  initial begin
    #200000;
    $display("aabb_box_sphere_collision_2d_core test failed");
    $finish;
  end
endmodule

### sim.f
rtl/absc_pkg.sv
rtl/absc_front.sv
rtl/absc_fifo.sv
rtl/absc_back.sv
rtl/aabb_box_sphere_collision_2d_core.sv
tb/collision_checker.sv
tb/testbench.sv
